// ----- hdl/aesr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aesr_pkg
// Shared types and GF(2^8) helpers for the AES round pipeline.
// ----------------------------------------------------------------------------
package aesr_pkg;

  typedef enum logic {
    CMD_FWD = 1'b0,
    CMD_INV = 1'b1
  } cmd_e;

  typedef logic [15:0][7:0] state_t;  // element 15 is byte 0

  typedef struct packed {
    logic   valid;
    cmd_e   cmd;
    logic   mix;
    state_t key;
  } ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, b);
      b = gf_mul(b, b);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // Inversion table; constant, built at elaboration.
  function automatic logic [255:0][7:0] inv_table();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) t[i] = gf_inv(8'(i));
    return t;
  endfunction

  localparam logic [255:0][7:0] InvTab = inv_table();

  function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
    logic [7:0] b;
    b = InvTab[x];
    return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] y);
    return InvTab[rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05];
  endfunction

  function automatic logic [7:0] byte_at(input state_t s, input int b);
    return s[15 - b];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/aes_round_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aes_round_core
// One AES-128 round (forward or inverse), three-stage pipeline.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high; busy is always low, so one
// round can be issued every cycle. The result passes the three register
// stages (S-box, then mix or key add, then key add or inverse mix) and is
// shown for one cycle, marked by done_o. The receiver cannot stall, and
// results arrive in request order.
module aes_round_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic        mix_enable_i,
  input  wire logic [63:0] state_hi_i,
  input  wire logic [63:0] state_lo_i,
  input  wire logic [63:0] key_hi_i,
  input  wire logic [63:0] key_lo_i,
  output logic             done_o,
  output logic [63:0]      result_hi_o,
  output logic [63:0]      result_lo_o
);

  aesr_pkg::ctl_t   ctl_in, ctl_s1;
  aesr_pkg::state_t st_s1, st_out;

  assign busy = 1'b0;

  always_comb begin
    ctl_in.valid = start & ~busy;
    ctl_in.cmd   = aesr_pkg::cmd_e'(command_i);
    ctl_in.mix   = mix_enable_i;
    ctl_in.key   = {key_hi_i, key_lo_i};
  end

  aesr_sub u_sub (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .state_i ({state_hi_i, state_lo_i}),
    .ctl_o   (ctl_s1),
    .state_o (st_s1)
  );

  aesr_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_s1),
    .state_i (st_s1),
    .valid_o (done_o),
    .state_o (st_out)
  );

  assign result_hi_o = st_out[15:8];
  assign result_lo_o = st_out[7:0];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3)) else $error("spurious result");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");
`endif

endmodule
`default_nettype wire

// ----- hdl/aesr_sub.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aesr_sub
// Stage 1: (inverse) ShiftRows and S-box, registered.
// ----------------------------------------------------------------------------
module aesr_sub (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire aesr_pkg::ctl_t  ctl_i,
  input  wire aesr_pkg::state_t state_i,
  output aesr_pkg::ctl_t       ctl_o,
  output aesr_pkg::state_t     state_o
);

  aesr_pkg::state_t sub_d, sub_q;
  logic valid_q;
  aesr_pkg::ctl_t ctl_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl_i.cmd == aesr_pkg::CMD_FWD)
          sub_d[15 - (c * 4 + r)] = aesr_pkg::sbox_fwd(
              aesr_pkg::byte_at(state_i, ((c + r) % 4) * 4 + r));
        else
          sub_d[15 - (c * 4 + r)] = aesr_pkg::sbox_inv(
              aesr_pkg::byte_at(state_i, ((c - r + 4) % 4) * 4 + r));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= ctl_i.valid;
  end

  always_ff @(posedge clk_i) begin
    sub_q <= sub_d;
    ctl_q <= ctl_i;
  end

  always_comb begin
    ctl_o = ctl_q;
    ctl_o.valid = valid_q;
  end
  assign state_o = sub_q;

endmodule
`default_nettype wire

// ----- hdl/aesr_mix.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aesr_mix
// Stages 2 and 3: key add and (inverse) MixColumns in the order the
// direction needs, each registered.
// ----------------------------------------------------------------------------
module aesr_mix (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire aesr_pkg::ctl_t   ctl_i,
  input  wire aesr_pkg::state_t state_i,
  output logic                  valid_o,
  output aesr_pkg::state_t      state_o
);

  function automatic aesr_pkg::state_t mixcols(input aesr_pkg::state_t s,
                                               input logic inv);
    aesr_pkg::state_t t;
    logic [3:0][7:0] m;
    logic [7:0] acc;
    m = inv ? {8'd9, 8'd13, 8'd11, 8'd14} : {8'd1, 8'd1, 8'd3, 8'd2};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc = acc ^ aesr_pkg::gf_mul(m[(k - r + 4) % 4],
                                        aesr_pkg::byte_at(s, c * 4 + k));
        t[15 - (c * 4 + r)] = acc;
      end
    end
    return t;
  endfunction

  // stage 2: forward mixes here when mix is set, inverse adds key here
  aesr_pkg::state_t s2_d, s2_q, s3_d, s3_q;
  aesr_pkg::ctl_t ctl2_q;
  logic v2_q, v3_q;
  logic inv;

  assign inv = (ctl_i.cmd == aesr_pkg::CMD_INV);

  always_comb begin
    if (inv) s2_d = state_i ^ ctl_i.key;
    else if (ctl_i.mix) s2_d = mixcols(state_i, 1'b0);
    else s2_d = state_i;
  end

  always_comb begin
    if (ctl2_q.cmd == aesr_pkg::CMD_INV)
      s3_d = ctl2_q.mix ? mixcols(s2_q, 1'b1) : s2_q;
    else
      s3_d = s2_q ^ ctl2_q.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= ctl_i.valid;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q   <= s2_d;
    ctl2_q <= ctl_i;
    s3_q   <= s3_d;
  end

  assign valid_o = v3_q;
  assign state_o = s3_q;

endmodule
`default_nettype wire

// ----- tb/aes_round_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes_round_checker
// Watches requests and results of the AES round core, predicts each round
// result independently and compares results in order.
// ----------------------------------------------------------------------------
module aes_round_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic        command_i,
  input  wire logic        mix_enable_i,
  input  wire logic [63:0] state_hi_i,
  input  wire logic [63:0] state_lo_i,
  input  wire logic [63:0] key_hi_i,
  input  wire logic [63:0] key_lo_i,
  input  wire logic        done_i,
  input  wire logic [63:0] result_hi_i,
  input  wire logic [63:0] result_lo_i,
  output int               errors_o,
  output int               pending_o
);

  logic [127:0] round_q[$];

  function automatic logic [7:0] xt(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xt(a);
    end
    return p;
  endfunction

  // x^254 by repeated multiply; zero maps to zero
  function automatic logic [7:0] finv(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = fmul(r, x);
    return r;
  endfunction

  function automatic logic [7:0] rol(input logic [7:0] v, input int n);
    logic [15:0] w;
    w = {v, v} << n;
    return w[15:8];
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] x, input bit inv);
    logic [7:0] b;
    if (!inv) begin
      b = finv(x);
      return b ^ rol(b, 1) ^ rol(b, 2) ^ rol(b, 3) ^ rol(b, 4) ^ 8'h63;
    end
    return finv(rol(x, 1) ^ rol(x, 3) ^ rol(x, 6) ^ 8'h05);
  endfunction

  function automatic logic [127:0] predict_round(input aesr_pkg::cmd_e cmd,
                                                 input logic mix,
                                                 input logic [127:0] st,
                                                 input logic [127:0] key);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] m[4];
    logic [7:0] col[4];
    logic [7:0] acc;
    logic [127:0] res;
    for (int b = 0; b < 16; b++) s[b] = st[127 - 8*b -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c*4 + r] = (cmd == aesr_pkg::CMD_FWD) ? sub_byte(s[((c + r) % 4)*4 + r], 0)
                                                : sub_byte(s[((c - r + 4) % 4)*4 + r], 1);
    if (cmd == aesr_pkg::CMD_INV)
      for (int b = 0; b < 16; b++) t[b] ^= key[127 - 8*b -: 8];
    if (mix) begin
      if (cmd == aesr_pkg::CMD_FWD) m = '{8'd2, 8'd3, 8'd1, 8'd1};
      else m = '{8'd14, 8'd11, 8'd13, 8'd9};
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc ^= fmul(m[(k - r + 4) % 4], t[c*4 + k]);
          col[r] = acc;
        end
        for (int r = 0; r < 4; r++) t[c*4 + r] = col[r];
      end
    end
    if (cmd == aesr_pkg::CMD_FWD)
      for (int b = 0; b < 16; b++) t[b] ^= key[127 - 8*b -: 8];
    for (int b = 0; b < 16; b++) res[127 - 8*b -: 8] = t[b];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (!rst_ni) begin
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (round_q.size() == 0) begin
          report_mismatch("unexpected result_hi", result_hi_i, 'x);
        end else begin
          want = round_q.pop_front();
          if (result_hi_i !== want[127:64]) report_mismatch("result_hi", result_hi_i, want[127:64]);
          if (result_lo_i !== want[63:0]) report_mismatch("result_lo", result_lo_i, want[63:0]);
        end
      end
      if (start_i && !busy_i)
        round_q.push_back(predict_round(aesr_pkg::cmd_e'(command_i), mix_enable_i,
                                        {state_hi_i, state_lo_i}, {key_hi_i, key_lo_i}));
      pending_o = round_q.size();
    end
  end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random round requests into the AES round core, with
// random gaps in some random phases; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Latency = 3;
  localparam int CycleLimit = 200000;

  logic clk_i, rst_ni, start, busy, done_o;
  logic command_i, mix_enable_i;
  logic [63:0] state_hi_i, state_lo_i, key_hi_i, key_lo_i, result_hi_o, result_lo_o;
  int errors, pending, cycles, gap_pct;

  aes_round_core uut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .mix_enable_i,
    .state_hi_i, .state_lo_i, .key_hi_i, .key_lo_i,
    .done_o, .result_hi_o, .result_lo_o
  );

  aes_round_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .mix_enable_i,
    .state_hi_i, .state_lo_i, .key_hi_i, .key_lo_i,
    .done_i(done_o), .result_hi_i(result_hi_o), .result_lo_i(result_lo_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one request; random idle cycles before it, start left high on return
  task automatic send_round(input aesr_pkg::cmd_e cmd, input logic mix,
                            input logic [63:0] sh, input logic [63:0] sl,
                            input logic [63:0] kh, input logic [63:0] kl);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    mix_enable_i <= mix;
    state_hi_i <= sh;
    state_lo_i <= sl;
    key_hi_i <= kh;
    key_lo_i <= kl;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] b;
    int wait_cyc;
    rst_ni = 0;
    start = 0;
    command_i = 0;
    mix_enable_i = 0;
    {state_hi_i, state_lo_i, key_hi_i, key_lo_i} = '0;
    gap_pct = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: each op/mix combination on all-zero, all-one and fixed pattern data
    for (int c = 0; c < 2; c++)
      for (int m = 0; m < 2; m++) begin
        send_round(aesr_pkg::cmd_e'(c), m[0], '0, '0, '0, '0);
        send_round(aesr_pkg::cmd_e'(c), m[0], '1, '1, '1, '1);
        send_round(aesr_pkg::cmd_e'(c), m[0], 64'h0011223344556677, 64'h8899aabbccddeeff,
                   64'h000102030405060a, 64'h08090a0b0c0d0e0f);
      end
    // walk a single 0x80 byte through the 8 byte positions of the high halves, low halves inverted
    for (int i = 0; i < 8; i++) begin
      b = 64'h80 << (8*i);
      send_round(aesr_pkg::cmd_e'(i[0]), i[1], b, ~b, b, ~b);
    end

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 22 : (ph == 1) ? 63 : 0;
      for (int n = 0; n < 165; n++)
        send_round(aesr_pkg::cmd_e'($urandom_range(1)), 1'($urandom_range(1)),
                   rand64(), rand64(), rand64(), rand64());
    end
    start <= 1'b0;

    wait_cyc = 0;
    while (pending != 0 && wait_cyc < 1000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (Latency + 5) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/aesr_pkg.sv
hdl/aesr_sub.sv
hdl/aesr_mix.sv
hdl/aes_round_core.sv
tb/aes_round_checker.sv
tb/tb_top.sv
